/* design/avcc_pkg.sv */
// Shared types and constants for the AVCC to Annex B converter.
`timescale 1ns / 1ps
`default_nettype none

package avcc_pkg;

  // Status codes carried on the final result of an access unit
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_LEN = 2'd1;
  localparam logic [1:0] ST_TRUNC    = 2'd2;

  // Index of the last start-code byte
  localparam logic [1:0] SC_LAST_IDX = 2'd3;

  typedef enum logic [1:0] {
    CMD_PASS,
    CMD_STATUS,
    CMD_START
  } cmd_kind_e;

  // One command from the parser to the emitter
  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] data;
    logic       last;
    logic [1:0] status;
  } cmd_t;

  // Annex B start code 00 00 00 01
  function automatic logic [7:0] start_code_byte(input logic [1:0] idx);
    logic [7:0] b;
    b = (idx == SC_LAST_IDX) ? 8'h01 : 8'h00;
    return b;
  endfunction

endpackage

`default_nettype wire

/* design/avcc_parser.sv */
// Front end: tracks length headers and payload, emits one command per byte at most.
`timescale 1ns / 1ps
`default_nettype none

module avcc_parser (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              accept_i,
  input  wire  [7:0]       in_byte_i,
  input  wire              in_last_i,
  output logic             cmd_valid_o,
  output avcc_pkg::cmd_t   cmd_o
);
  import avcc_pkg::*;

  logic [1:0]  header_index_q, header_index_d;
  logic [23:0] length_accum_q, length_accum_d;
  logic [31:0] payload_left_q, payload_left_d;
  logic        in_payload_q, in_payload_d;
  logic [1:0]  error_code_q, error_code_d;

  logic [31:0] left_dec;
  logic        still_in;
  logic [31:0] full_len;

  assign left_dec = payload_left_q - 32'd1;
  assign still_in = (left_dec != 32'd0);
  assign full_len = {length_accum_q, in_byte_i};

  always_comb begin
    header_index_d = header_index_q;
    length_accum_d = length_accum_q;
    payload_left_d = payload_left_q;
    in_payload_d   = in_payload_q;
    error_code_d   = error_code_q;
    cmd_valid_o    = 1'b0;
    cmd_o.kind     = CMD_STATUS;
    cmd_o.data     = 8'h00;
    cmd_o.last     = 1'b1;
    cmd_o.status   = ST_OK;

    if (accept_i) begin
      if (error_code_q != ST_OK) begin
        // discarding the rest of a bad packet
        if (in_last_i) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = error_code_q;
        end
      end else if (in_payload_q) begin
        cmd_valid_o    = 1'b1;
        cmd_o.kind     = CMD_PASS;
        cmd_o.data     = in_byte_i;
        cmd_o.last     = in_last_i;
        payload_left_d = left_dec;
        in_payload_d   = still_in;
        if (in_last_i) begin
          cmd_o.status = still_in ? ST_TRUNC : ST_OK;
        end
      end else if (header_index_q != SC_LAST_IDX) begin
        length_accum_d = {length_accum_q[15:0], in_byte_i};
        header_index_d = header_index_q + 2'd1;
        if (in_last_i) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_TRUNC;
        end
      end else begin
        header_index_d = 2'd0;
        length_accum_d = 24'd0;
        if (full_len == 32'd0) begin
          if (in_last_i) begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = ST_ZERO_LEN;
          end else begin
            error_code_d = ST_ZERO_LEN;
          end
        end else if (in_last_i) begin
          cmd_valid_o  = 1'b1;
          cmd_o.status = ST_TRUNC;
        end else begin
          payload_left_d = full_len;
          in_payload_d   = 1'b1;
          cmd_valid_o    = 1'b1;
          cmd_o.kind     = CMD_START;
          cmd_o.last     = 1'b0;
        end
      end

      // every final result ends the packet
      if (in_last_i) begin
        header_index_d = 2'd0;
        length_accum_d = 24'd0;
        payload_left_d = 32'd0;
        in_payload_d   = 1'b0;
        error_code_d   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_index_q <= 2'd0;
      length_accum_q <= 24'd0;
      payload_left_q <= 32'd0;
      in_payload_q   <= 1'b0;
      error_code_q   <= ST_OK;
    end else begin
      header_index_q <= header_index_d;
      length_accum_q <= length_accum_d;
      payload_left_q <= payload_left_d;
      in_payload_q   <= in_payload_d;
      error_code_q   <= error_code_d;
    end
  end

endmodule

`default_nettype wire

/* design/avcc_cmd_fifo.sv */
// Short command queue between parser and emitter.
`timescale 1ns / 1ps
`default_nettype none

module avcc_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  avcc_pkg::cmd_t   wdata_i,
  output logic             full_o,
  input  wire              pop_i,
  output logic             empty_o,
  output avcc_pkg::cmd_t   rdata_o
);
  import avcc_pkg::*;

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

/* design/avcc_emitter.sv */
// Back end: expands commands into output results (bytes or status-only) behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module avcc_emitter (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cmd_empty_i,
  input  avcc_pkg::cmd_t   cmd_i,
  output logic             cmd_pop_o,
  input  wire              pop,
  output logic             empty,
  output logic [7:0]       out_byte_o,
  output logic             byte_valid_o,
  output logic             out_last_o,
  output logic [1:0]       status_o
);
  import avcc_pkg::*;

  logic       out_valid_q;
  logic [1:0] sc_idx_q;
  logic       load;
  logic [7:0] byte_d;
  logic       bvalid_d;

  assign empty     = !out_valid_q;
  assign load      = !cmd_empty_i && (!out_valid_q || pop);
  assign cmd_pop_o = load && ((cmd_i.kind != CMD_START) || (sc_idx_q == SC_LAST_IDX));

  always_comb begin
    unique case (cmd_i.kind)
      CMD_PASS: begin
        byte_d   = cmd_i.data;
        bvalid_d = 1'b1;
      end
      CMD_START: begin
        byte_d   = start_code_byte(sc_idx_q);
        bvalid_d = 1'b1;
      end
      CMD_STATUS: begin
        byte_d   = 8'h00;
        bvalid_d = 1'b0;
      end
      default: begin
        byte_d   = 8'h00;
        bvalid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_byte_o   <= byte_d;
      byte_valid_o <= bvalid_d;
      out_last_o   <= cmd_i.last;
      status_o     <= cmd_i.status;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      sc_idx_q    <= 2'd0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
      if (load && (cmd_i.kind == CMD_START)) begin
        sc_idx_q <= sc_idx_q + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/avcc_to_annexb_converter.sv */
// Top level of the AVCC (length-prefixed) to Annex B (start-code) converter.
//
// Input channel: one byte of an access unit per transaction, with in_last_i
// on its final byte. A transaction completes on a clock edge with push high
// and full low. Result channel: the oldest result sits on the output ports
// while empty is low and is taken on an edge with pop high.
// Each 4-byte length header with a nonzero length yields the start code
// 00 00 00 01, each payload byte passes through. Errors (zero length, packet
// ending inside a header or payload) drop the rest of the packet; status shows
// on its final result. A result passes through the command queue, written at
// the accepting edge, and then the output register, loaded from the queue.
// Throughput: one byte per cycle in while full is low; the emitter sends one
// result per cycle while pop is high, and a header's fourth byte expands into
// four results, which the three silent header bytes before it pay for, so the
// stream keeps full rate as long as the queue holds at least five commands (a
// start command plus the payload commands that arrive while it is expanded).
// Reset (rst_ni low, asynchronous) empties queue and output register and
// clears the parser state. When the receiver stalls the output register
// holds, the queue fills, and full rises to stall the sender; no result is
// lost.
`timescale 1ns / 1ps
`default_nettype none

module avcc_to_annexb_converter #(
  parameter int unsigned CMD_DEPTH = 8
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        push,
  output logic       full,
  input  wire  [7:0] in_byte_i,
  input  wire        in_last_i,
  output logic       empty,
  input  wire        pop,
  output logic [7:0] out_byte_o,
  output logic       byte_valid_o,
  output logic       out_last_o,
  output logic [1:0] status_o
);
  import avcc_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd_wr;
  cmd_t cmd_rd;
  logic cmd_empty;
  logic cmd_pop;

  // Every accepted byte advances the parser, whether or not it makes a command
  assign accept = push && !full;

  avcc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr)
  );

  avcc_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .wdata_i (cmd_wr),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .empty_o (cmd_empty),
    .rdata_o (cmd_rd)
  );

  avcc_emitter u_emitter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_empty_i  (cmd_empty),
    .cmd_i        (cmd_rd),
    .cmd_pop_o    (cmd_pop),
    .pop          (pop),
    .empty        (empty),
    .out_byte_o   (out_byte_o),
    .byte_valid_o (byte_valid_o),
    .out_last_o   (out_last_o),
    .status_o     (status_o)
  );

endmodule

`default_nettype wire

/* design/avcc_checker.sv */
// Port-level checks for the converter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module avcc_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       empty,
  input wire       pop,
  input wire [7:0] out_byte_o,
  input wire       byte_valid_o,
  input wire       out_last_o,
  input wire [1:0] status_o
);
  import avcc_pkg::*;

  // A nonzero status only appears on the final result of a packet
  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_last_o || status_o == ST_OK))
    else $error("status set on a non-final result");

  // Status never takes the unused code
  a_status_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (status_o == ST_OK || status_o == ST_ZERO_LEN || status_o == ST_TRUNC))
    else $error("illegal status code");

  // A status-only result is the final one and carries a zero byte
  a_status_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !byte_valid_o) |-> (out_last_o && out_byte_o == 8'h00))
    else $error("status-only result not final or byte not zero");

  // A stalled result holds
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(byte_valid_o)
                          && $stable(out_last_o) && $stable(status_o)))
    else $error("result changed while stalled");

endmodule

bind avcc_to_annexb_converter avcc_checker u_avcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .empty        (empty),
  .pop          (pop),
  .out_byte_o   (out_byte_o),
  .byte_valid_o (byte_valid_o),
  .out_last_o   (out_last_o),
  .status_o     (status_o)
);

`default_nettype wire
